// ===== rtl/rlss_pkg.sv =====
// shared types and constants for the rgb led strip serializer
package rlss_pkg;

  localparam int LED_COUNT_DEF = 20;
  localparam int BITS_PER_LED  = 24;
  localparam int TICK_W        = 15;
  localparam int CFG_IDX_W     = 3;

  localparam logic OP_TICK = 1'b0;
  localparam logic OP_SET  = 1'b1;

  localparam logic [CFG_IDX_W-1:0] REG_ZERO_HIGH = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ZERO_LOW  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ONE_HIGH  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_ONE_LOW   = 3'd3;

  localparam logic [TICK_W-1:0] ZERO_HIGH_RST = 15'd8;
  localparam logic [TICK_W-1:0] ZERO_LOW_RST  = 15'd17;
  localparam logic [TICK_W-1:0] ONE_HIGH_RST  = 15'd16;
  localparam logic [TICK_W-1:0] ONE_LOW_RST   = 15'd9;

  typedef struct packed {
    logic       operation;
    logic [7:0] position;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] run_length;
    logic       send_after;
  } in_t;

  typedef struct packed {
    logic line_level;
    logic busy_res;
    logic frame_done;
    logic set_ignored;
  } out_t;

  typedef struct packed {
    logic tick;
    logic set;
    logic fill_step;
    logic load_addr;
    logic load_cap;
  } dp_cmd_t;

  typedef struct packed {
    logic sending;
    logic run_zero;
    logic fill_last;
    logic send_pend;
  } dp_status_t;

endpackage

// ===== rtl/rlss_ram.sv =====
// generic single write port ram with registered read
module rlss_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 20
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/rlss_ctrl.sv =====
// controller: handshake, result valid and fill / pixel load sequencing
module rlss_ctrl (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic                   operation,
  input  logic                   send_after,
  output logic                   out_valid,
  input  logic                   out_ready,
  input  rlss_pkg::dp_status_t   status,
  output rlss_pkg::dp_cmd_t      cmd
);
  import rlss_pkg::*;

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_FILL  = 2'd1;
  localparam logic [1:0] S_LOAD  = 2'd2;
  localparam logic [1:0] S_LOAD2 = 2'd3;

  logic [1:0] state;
  logic [1:0] state_next;
  logic       accept;

  assign in_ready = (state == S_IDLE) && (!out_valid || out_ready);
  assign accept   = in_valid && in_ready;

  always_comb begin
    cmd            = '0;
    state_next     = state;
    cmd.tick       = accept && (operation == OP_TICK);
    cmd.set        = accept && (operation == OP_SET);
    case (state)
      S_IDLE: begin
        if (cmd.set && !status.sending) begin
          if (!status.run_zero) begin
            state_next = S_FILL;
          end else if (send_after) begin
            state_next = S_LOAD;
          end
        end
      end
      S_FILL: begin
        cmd.fill_step = 1'b1;
        if (status.fill_last) begin
          state_next = status.send_pend ? S_LOAD : S_IDLE;
        end
      end
      S_LOAD: begin
        // read of the first led in flight
        cmd.load_addr = 1'b1;
        state_next    = S_LOAD2;
      end
      S_LOAD2: begin
        cmd.load_cap = 1'b1;
        state_next   = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (accept) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

// ===== rtl/rlss_datapath.sv =====
// datapath: pixel store, run fill, bit timing and result register
module rlss_datapath #(
  parameter int LED_COUNT = rlss_pkg::LED_COUNT_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  rlss_pkg::in_t                         in_data,
  input  rlss_pkg::dp_cmd_t                     cmd,
  output rlss_pkg::dp_status_t                  status,
  output rlss_pkg::out_t                        out_data,
  input  logic                                  cfg_we,
  input  logic [rlss_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [rlss_pkg::TICK_W-1:0]           cfg_data
);
  import rlss_pkg::*;

  localparam int IDX_W = (LED_COUNT > 1) ? $clog2(LED_COUNT) : 1;
  localparam int CNT_W = $clog2(LED_COUNT + 1);
  localparam logic [8:0]       N9       = 9'(LED_COUNT);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(LED_COUNT - 1);
  localparam logic [4:0]       LAST_BIT = 5'(BITS_PER_LED - 1);

  logic [TICK_W-1:0] zero_high;
  logic [TICK_W-1:0] zero_low;
  logic [TICK_W-1:0] one_high;
  logic [TICK_W-1:0] one_low;

  logic              sending;
  logic [IDX_W-1:0]  led_index;
  logic [4:0]        bit_index;
  logic              in_low_phase;
  logic [TICK_W-1:0] tick_count;
  logic [23:0]       cur_pixel;

  logic [IDX_W-1:0]  fill_addr;
  logic [CNT_W-1:0]  fill_left;
  logic [23:0]       fill_colour;
  logic              send_pend;
  logic [LED_COUNT-1:0] valid;
  logic              valid_q;

  logic [IDX_W-1:0]  rd_addr;
  logic [23:0]       rd_data;
  logic [23:0]       rd_pixel;

  logic [8:0]        pos9;
  logic [8:0]        pos_c;
  logic [8:0]        room;
  logic [8:0]        len9;
  logic [8:0]        cnt_c;

  logic              cur_bit;
  logic [TICK_W-1:0] phase_len;
  logic [TICK_W-1:0] tick_next;
  logic              phase_end;
  logic              bit_end;
  logic              led_end;
  logic              frame_end;

  // clamp position to 1..LED_COUNT and the run to the strip end
  always_comb begin
    pos9 = {1'b0, in_data.position};
    if (pos9 == 9'd0) begin
      pos_c = 9'd1;
    end else if (pos9 > N9) begin
      pos_c = N9;
    end else begin
      pos_c = pos9;
    end
    room  = N9 - pos_c + 9'd1;
    len9  = {1'b0, in_data.run_length};
    cnt_c = (len9 > room) ? room : len9;
  end

  assign status.sending   = sending;
  assign status.run_zero  = (cnt_c == 9'd0);
  assign status.fill_last = (fill_left == CNT_W'(1));
  assign status.send_pend = send_pend;

  // prefetch the next led so it is ready when the current one ends
  always_comb begin
    if (cmd.load_addr) begin
      rd_addr = '0;
    end else if (led_index == LAST_IDX) begin
      rd_addr = '0;
    end else begin
      rd_addr = led_index + IDX_W'(1);
    end
  end

  rlss_ram #(
    .WIDTH (24),
    .DEPTH (LED_COUNT)
  ) u_ram (
    .clk   (clk),
    .we    (cmd.fill_step),
    .waddr (fill_addr),
    .wdata (fill_colour),
    .raddr (rd_addr),
    .rdata (rd_data)
  );

  always_ff @(posedge clk) begin
    valid_q <= valid[rd_addr];
  end

  assign rd_pixel = rd_data & {24{valid_q}};

  always_comb begin
    cur_bit = cur_pixel[23];
    if (in_low_phase) begin
      phase_len = cur_bit ? one_low : zero_low;
    end else begin
      phase_len = cur_bit ? one_high : zero_high;
    end
    tick_next = tick_count + TICK_W'(1);
    // a zero length ends the phase at once
    phase_end = (tick_next >= phase_len);
    bit_end   = phase_end && in_low_phase;
    led_end   = bit_end && (bit_index == LAST_BIT);
    frame_end = led_end && (led_index == LAST_IDX);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      zero_high    <= ZERO_HIGH_RST;
      zero_low     <= ZERO_LOW_RST;
      one_high     <= ONE_HIGH_RST;
      one_low      <= ONE_LOW_RST;
      sending      <= 1'b0;
      led_index    <= '0;
      bit_index    <= '0;
      in_low_phase <= 1'b0;
      tick_count   <= '0;
      cur_pixel    <= '0;
      fill_addr    <= '0;
      fill_left    <= '0;
      fill_colour  <= '0;
      send_pend    <= 1'b0;
      valid        <= '0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_ZERO_HIGH: zero_high <= cfg_data;
          REG_ZERO_LOW:  zero_low  <= cfg_data;
          REG_ONE_HIGH:  one_high  <= cfg_data;
          REG_ONE_LOW:   one_low   <= cfg_data;
          default: ;
        endcase
      end

      if (cmd.set && !sending) begin
        fill_addr   <= pos_c[IDX_W-1:0] - IDX_W'(1);
        fill_left   <= CNT_W'(cnt_c);
        fill_colour <= {in_data.green, in_data.red, in_data.blue};
        send_pend   <= in_data.send_after;
        if (in_data.send_after) begin
          sending      <= 1'b1;
          led_index    <= '0;
          bit_index    <= '0;
          in_low_phase <= 1'b0;
          tick_count   <= '0;
        end
      end

      if (cmd.fill_step) begin
        valid[fill_addr] <= 1'b1;
        fill_addr        <= fill_addr + IDX_W'(1);
        fill_left        <= fill_left - CNT_W'(1);
      end

      if (cmd.load_cap) begin
        cur_pixel <= rd_pixel;
      end

      if (cmd.tick && sending) begin
        if (!phase_end) begin
          tick_count <= tick_next;
        end else begin
          tick_count   <= '0;
          in_low_phase <= !in_low_phase;
          if (bit_end) begin
            if (led_end) begin
              bit_index <= '0;
              cur_pixel <= rd_pixel;
              if (frame_end) begin
                led_index <= '0;
                sending   <= 1'b0;
              end else begin
                led_index <= led_index + IDX_W'(1);
              end
            end else begin
              bit_index <= bit_index + 5'd1;
              cur_pixel <= {cur_pixel[22:0], 1'b0};
            end
          end
        end
      end
    end
  end

  // result register, loaded on every input transfer
  always_ff @(posedge clk) begin
    if (cmd.tick) begin
      out_data.line_level  <= sending && !in_low_phase;
      out_data.busy_res    <= sending;
      out_data.frame_done  <= sending && frame_end;
      out_data.set_ignored <= 1'b0;
    end else if (cmd.set) begin
      out_data.line_level  <= sending ? !in_low_phase : in_data.send_after;
      out_data.busy_res    <= sending || in_data.send_after;
      out_data.frame_done  <= 1'b0;
      out_data.set_ignored <= sending;
    end
  end

endmodule

// ===== rtl/rgb_led_strip_serializer_top.sv =====
// serial rgb led strip driver: pixel store and tick-timed bit serializer
// result: the result of an item is registered and valid in the cycle after its transfer
// throughput: a tick item can be taken every cycle while idle and the result is not stalled
// a set item holds off the input while it writes its clamped run (one store write per cycle),
//   then fetches the first pixel (S_LOAD, S_LOAD2) to start a frame; ignored sets write none
// reset: synchronous; pixel valid bits clear at once, so the store reads as zero
module rgb_led_strip_serializer_top #(
  parameter int LED_COUNT = rlss_pkg::LED_COUNT_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  rlss_pkg::in_t                  in_data,
  output logic                           out_valid,
  input  logic                           out_ready,
  output rlss_pkg::out_t                 out_data,
  input  logic                           cfg_we,
  input  logic [rlss_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [rlss_pkg::TICK_W-1:0]    cfg_data
);
  import rlss_pkg::*;

  dp_cmd_t    cmd;
  dp_status_t status;

  rlss_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .operation  (in_data.operation),
    .send_after (in_data.send_after),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .status     (status),
    .cmd        (cmd)
  );

  rlss_datapath #(
    .LED_COUNT (LED_COUNT)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .in_data   (in_data),
    .cmd       (cmd),
    .status    (status),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

endmodule

// ===== rtl/rlss_checker.sv =====
// port-level checks for the serializer top, attached by bind
module rlss_checker (
  input logic           clk,
  input logic           rst,
  input logic           out_valid,
  input logic           out_ready,
  input rlss_pkg::out_t out_data
);
  import rlss_pkg::*;

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  // frame end only on a tick that was sending
  a_done_busy: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.frame_done |-> out_data.busy_res && !out_data.set_ignored)
    else $error("frame_done without busy");

  a_ignored_busy: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.set_ignored |-> out_data.busy_res && !out_data.frame_done)
    else $error("set ignored while idle");

  // line idles low
  a_level_busy: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.line_level |-> out_data.busy_res)
    else $error("line high while idle");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind rgb_led_strip_serializer_top rlss_checker u_checker (
  .clk       (clk),
  .rst       (rst),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);

// ===== tb/testbench.sv =====
`timescale 1ns / 100ps
// testbench for the rgb led strip serializer: predicts and checks every line status result
module testbench;
  import rlss_pkg::*;

  localparam int LEDS = LED_COUNT_DEF;
  localparam int CYCLE_LIMIT = 100000;
  localparam int SETTLE_CYCLES = 32;
  localparam int TICK_BATCH = 256;
  localparam logic [TICK_W-1:0] TICKS_MAX = {TICK_W{1'b1}};

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  in_t                  in_data = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  out_t                 out_data;
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [TICK_W-1:0]    cfg_data = '0;

  // items waiting for the driver, and line status expected from the block
  in_t  strip_items [$];
  out_t status_expected [$];

  // mirror of the block state
  logic [23:0]       pixel_mirror [LEDS];
  logic [TICK_W-1:0] phase_cfg [2 ** CFG_IDX_W];
  logic              frame_active;
  logic              low_phase;
  int                led_pos;
  int                bit_pos;
  logic [TICK_W-1:0] phase_ticks;

  int   send_idle_pct = 0;
  int   recv_idle_pct = 0;
  int   fail_count = 0;
  int   cycle_count = 0;
  logic in_xfer = 1'b0;

  rgb_led_strip_serializer_top i_dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic void clear_strip();
    foreach (pixel_mirror[i]) pixel_mirror[i] = '0;
    frame_active = 1'b0;
    low_phase = 1'b0;
    led_pos = 0;
    bit_pos = 0;
    phase_ticks = '0;
    phase_cfg[REG_ZERO_HIGH] = ZERO_HIGH_RST;
    phase_cfg[REG_ZERO_LOW] = ZERO_LOW_RST;
    phase_cfg[REG_ONE_HIGH] = ONE_HIGH_RST;
    phase_cfg[REG_ONE_LOW] = ONE_LOW_RST;
  endfunction

  function automatic out_t advance_strip(in_t it);
    out_t              res;
    int                first;
    int                count;
    logic              bit_now;
    logic [TICK_W-1:0] span;
    res = '0;
    if (it.operation == OP_SET) begin
      if (frame_active) begin
        res.set_ignored = 1'b1;
      end else begin
        first = int'(it.position);
        if (first < 1) first = 1;
        if (first > LEDS) first = LEDS;
        count = int'(it.run_length);
        if (count > LEDS - first + 1) count = LEDS - first + 1;
        for (int i = first - 1; i < first - 1 + count; i++)
          pixel_mirror[i] = {it.green, it.red, it.blue};
        if (it.send_after) begin
          frame_active = 1'b1;
          led_pos = 0;
          bit_pos = 0;
          low_phase = 1'b0;
          phase_ticks = '0;
        end
      end
      res.busy_res = frame_active;
      res.line_level = frame_active && !low_phase;
    end else if (frame_active) begin
      bit_now = pixel_mirror[led_pos][23 - bit_pos];
      if (bit_now) span = low_phase ? phase_cfg[REG_ONE_LOW] : phase_cfg[REG_ONE_HIGH];
      else span = low_phase ? phase_cfg[REG_ZERO_LOW] : phase_cfg[REG_ZERO_HIGH];
      res.busy_res = 1'b1;
      res.line_level = !low_phase;
      phase_ticks = phase_ticks + 1'b1;
      if (phase_ticks >= span) begin
        phase_ticks = '0;
        if (!low_phase) begin
          low_phase = 1'b1;
        end else begin
          low_phase = 1'b0;
          bit_pos++;
          if (bit_pos >= BITS_PER_LED) begin
            bit_pos = 0;
            led_pos++;
            if (led_pos >= LEDS) begin
              led_pos = 0;
              frame_active = 1'b0;
              res.frame_done = 1'b1;
            end
          end
        end
      end
    end
    return res;
  endfunction

  task automatic check_field(string name, logic want, logic got);
    if (got !== want) begin
      $error("%s: expected %0b, actual %0b", name, want, got);
      fail_count++;
    end
  endtask

  // monitor: tracks transfers on both channels and register writes
  always @(posedge clk) begin
    out_t want;
    if (rst) begin
      clear_strip();
      in_xfer = 1'b0;
    end else begin
      if (cfg_we && cfg_index <= REG_ONE_LOW) phase_cfg[cfg_index] = cfg_data;
      in_xfer = in_valid && in_ready;
      if (in_xfer) status_expected.push_back(advance_strip(in_data));
      if (out_valid && out_ready) begin
        if (status_expected.size() == 0) begin
          $error("unexpected result transfer: %b", out_data);
          fail_count++;
        end else begin
          want = status_expected.pop_front();
          check_field("line_level", want.line_level, out_data.line_level);
          check_field("busy_res", want.busy_res, out_data.busy_res);
          check_field("frame_done", want.frame_done, out_data.frame_done);
          check_field("set_ignored", want.set_ignored, out_data.set_ignored);
        end
      end
    end
  end

  // driver: inputs move on the falling edge
  always @(negedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_idle_pct);
      if (!in_valid || in_xfer) begin
        if (strip_items.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          in_data <= strip_items.pop_front();
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("testbench: errors");
      $finish;
    end
  end

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [TICK_W-1:0] val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    #1;
  endtask

  task automatic set_timing(logic [TICK_W-1:0] zero_hi, logic [TICK_W-1:0] zero_lo,
                            logic [TICK_W-1:0] one_hi, logic [TICK_W-1:0] one_lo);
    write_reg(REG_ZERO_HIGH, zero_hi);
    write_reg(REG_ZERO_LOW, zero_lo);
    write_reg(REG_ONE_HIGH, one_hi);
    write_reg(REG_ONE_LOW, one_lo);
  endtask

  task automatic push_tick();
    in_t it;
    it.operation = OP_TICK;
    it.position = 8'($urandom_range(255));
    it.red = 8'($urandom_range(255));
    it.green = 8'($urandom_range(255));
    it.blue = 8'($urandom_range(255));
    it.run_length = 8'($urandom_range(255));
    it.send_after = 1'($urandom_range(1));
    strip_items.push_back(it);
  endtask

  task automatic push_set(logic [7:0] pos, logic [7:0] r, logic [7:0] g, logic [7:0] b,
                          logic [7:0] len, logic send);
    in_t it;
    it.operation = OP_SET;
    it.position = pos;
    it.red = r;
    it.green = g;
    it.blue = b;
    it.run_length = len;
    it.send_after = send;
    strip_items.push_back(it);
  endtask

  // positions and lengths mostly fall in or just past the strip but cover the whole byte
  task automatic push_random_set(logic send);
    logic [7:0] pos;
    logic [7:0] len;
    pos = 8'(($urandom_range(3) == 0) ? $urandom_range(255) : $urandom_range(LEDS + 1));
    len = 8'(($urandom_range(3) == 0) ? $urandom_range(255) : $urandom_range(LEDS + 1));
    push_set(pos, 8'($urandom_range(255)), 8'($urandom_range(255)), 8'($urandom_range(255)),
             len, send);
  endtask

  task automatic wait_drained();
    do begin
      @(posedge clk);
      #1;
    end while (strip_items.size() != 0 || in_valid || status_expected.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
    #1;
  endtask

  // keep ticking until the frame in flight has gone out
  task automatic finish_frame();
    wait_drained();
    while (frame_active) begin
      repeat (TICK_BATCH) push_tick();
      wait_drained();
    end
  endtask

  // fill runs, now and then ending in a frame start, then ticks with stray sets mixed in
  task automatic random_traffic(int count);
    int made;
    int fills;
    int ticks;
    made = 0;
    while (made < count) begin
      fills = $urandom_range(1, 4);
      for (int j = 0; j < fills; j++) begin
        push_random_set((j == fills - 1) && ($urandom_range(9) == 0));
        made++;
      end
      ticks = $urandom_range(10, 60);
      for (int j = 0; j < ticks && made < count; j++) begin
        if ($urandom_range(99) < 4) push_random_set($urandom_range(7) == 0);
        else push_tick();
        made++;
      end
    end
  endtask

  initial begin
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(posedge clk);
    #1;

    send_idle_pct = 13;
    recv_idle_pct = 74;
    // writes past the last register must leave the default timing alone
    for (int i = REG_ONE_LOW + 1; i < 2 ** CFG_IDX_W; i++)
      write_reg(CFG_IDX_W'(i), TICK_W'($urandom_range(1, 5)));
    push_tick();
    push_set(8'd0, 8'hff, 8'hff, 8'hff, 8'd255, 1'b0);
    push_set(8'd255, 8'h00, 8'h00, 8'h00, 8'd255, 1'b0);
    push_set(8'd20, 8'h12, 8'h34, 8'h56, 8'd0, 1'b0);
    push_set(8'd1, 8'ha5, 8'h5a, 8'h0f, 8'd1, 1'b0);
    push_set(8'd5, 8'h80, 8'h01, 8'hfe, 8'd3, 1'b0);
    push_set(8'd18, 8'h3c, 8'hc3, 8'h99, 8'd200, 1'b0);
    // empty run still starts the frame
    push_set(8'd10, 8'h00, 8'h00, 8'h00, 8'd0, 1'b1);
    repeat (3) push_tick();
    push_set(8'd2, 8'h11, 8'h22, 8'h33, 8'd4, 1'b1);
    push_tick();
    push_set(8'd0, 8'hff, 8'h00, 8'hff, 8'd255, 1'b0);
    repeat (40) push_tick();
    wait_drained();
    // timing change mid frame, zero length acting as one tick
    set_timing(15'd1, 15'd0, 15'd1, 15'd1);
    finish_frame();

    set_timing(TICK_W'($urandom_range(1, 4)), TICK_W'($urandom_range(1, 4)),
               TICK_W'($urandom_range(1, 4)), TICK_W'($urandom_range(1, 4)));
    random_traffic(120);
    wait_drained();

    send_idle_pct = 74;
    recv_idle_pct = 13;
    set_timing(TICK_W'($urandom_range(1, 4)), TICK_W'($urandom_range(1, 4)),
               TICK_W'($urandom_range(1, 4)), TICK_W'($urandom_range(1, 4)));
    random_traffic(120);
    wait_drained();

    send_idle_pct = 0;
    recv_idle_pct = 0;
    set_timing(15'd1, 15'd1, 15'd1, 15'd1);
    random_traffic(120);
    wait_drained();

    // longest phases, cut short by a write in the middle of a phase
    push_set(8'd3, 8'h0f, 8'hf0, 8'h3c, 8'd2, 1'b1);
    wait_drained();
    set_timing(TICKS_MAX, TICKS_MAX, TICKS_MAX, TICKS_MAX);
    repeat (24) push_tick();
    wait_drained();
    set_timing(15'd1, 15'd1, 15'd1, 15'd1);
    repeat (8) push_tick();
    wait_drained();

    if (fail_count == 0) begin
      $display("testbench: clean");
    end else begin
      $display("testbench: errors");
    end
    $finish;
  end

endmodule
